@@ hdl/aics_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aics_pkg
// Shared types, codes and helpers of the box collision step unit.
// ----------------------------------------------------------------------------
package aics_pkg;

   // default table depth
   localparam int DEF_MAX_BOXES = 16;

   // fixed datapath widths
   localparam int BIG_W  = 93;   // wide accumulator and divisor
   localparam int MAG_W  = 49;   // impulse numerator and magnitude
   localparam int PROD_W = 68;   // shared multiplier product
   localparam int OPR_W  = 34;   // shared multiplier operands
   localparam int STEP_W = 6;    // divider step counter
   localparam int DLT_W  = 41;   // capped velocity change

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // request commands
   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_STEP = 2'd1,
      CMD_READ = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // one table entry
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        ext_x;
      logic [30:0]        ext_y;
      logic [31:0]        inv_mass;
      logic [16:0]        bounce;
   } box_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_SAVE_P,
      OP_IM_SAT,
      OP_DIV_IM,
      OP_TAKE_IM,
      OP_WRITE_NEW,
      OP_LOAD_A,
      OP_LOAD_B,
      OP_MOVE_X,
      OP_MOVE_Y,
      OP_DIFF,
      OP_SEP,
      OP_DIV_MAG,
      OP_TAKE_MAG,
      OP_CAP_A,
      OP_CAP_B,
      OP_APPLY,
      OP_WRITE_A,
      OP_WRITE_B
   } dp_op_type;

   // multiplier operand selection
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_HWHH,
      MUL_PLO,
      MUL_PHI,
      MUL_VX,
      MUL_VY,
      MUL_NUM,
      MUL_MLO_A,
      MUL_MHI_A,
      MUL_MLO_B,
      MUL_MHI_B
   } mul_sel_type;

   // accumulator operation
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_SET,
      ACC_ADD31,
      ACC_ADD25
   } acc_op_type;

   // result selection
   typedef enum logic [1:0] {
      RES_OK,
      RES_FULL,
      RES_RANGE,
      RES_READ
   } res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      dp_op_type   op;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic overlap;
      logic approach;
      logic small_mass;
      logic div_busy;
   } dp_stat_type;

   // controller states
   typedef enum logic [5:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_M1,
      S_ADD_M2,
      S_ADD_M3,
      S_ADD_M4,
      S_ADD_M5,
      S_ADD_CHK,
      S_ADD_DIV0,
      S_ADD_DIV,
      S_ADD_TAKE,
      S_ADD_WR,
      S_RD_ADDR,
      S_RD_LOAD,
      S_MV_RA,
      S_MV_LA,
      S_MV_MX,
      S_MV_AX,
      S_MV_AY,
      S_PR_RB,
      S_PR_LB,
      S_PR_DIFF,
      S_PR_TEST,
      S_PR_APPR,
      S_PR_DIV0,
      S_PR_DIV,
      S_PR_TAKE,
      S_SC1,
      S_SC2,
      S_SC3,
      S_SC4,
      S_SC5,
      S_SC6,
      S_PR_UPD,
      S_PR_WB,
      S_PR_NEXT,
      S_MV_WA,
      S_RESULT
   } ctl_state_type;

   // saturate a signed 64-bit value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/aics_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aics_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aics_divider import aics_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [BIG_W-1:0]   rem_init,
   input  wire logic [MAG_W-1:0]   dividend,
   input  wire logic [BIG_W-1:0]   divisor,
   input  wire logic [STEP_W-1:0]  steps,
   output logic                    busy,
   output logic [MAG_W-1:0]        quotient
);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [BIG_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]    dvd_ff, dvd_in;
   logic [MAG_W-1:0]    quo_ff, quo_in;
   logic [BIG_W-1:0]    dsr_ff, dsr_in;
   logic [BIG_W:0]      trial;
   logic [BIG_W:0]      diff;

   // one shift and trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[MAG_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         dvd_in  = dividend;
         quo_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[MAG_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[BIG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BIG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ hdl/aics_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aics_datapath
// Box table memory, working boxes, shared multiplier, accumulator, divider
// and result register.
// ----------------------------------------------------------------------------
module aics_datapath import aics_pkg::*; #(
   parameter int MAX_BOXES = DEF_MAX_BOXES,
   parameter int ADDR_W    = $clog2(MAX_BOXES),
   parameter int CNT_W     = $clog2(MAX_BOXES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_stat_type             stat,
   input  wire logic [ADDR_W-1:0]  addr,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic [199:0]       req_data,
   output logic [1:0]              res_status,
   output logic [135:0]            res_data
);

   // captured request payload
   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0]        hw_ff, hh_ff, dens_ff;
   logic [16:0]        rest_ff, dt_ff;

   // table memory
   box_type            box_mem_ff [MAX_BOXES];
   box_type            rd_q_ff;
   logic               mem_wr;
   box_type            mem_wdata;

   // working boxes and intermediates
   box_type            a_ff, a_in;
   box_type            b_ff, b_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [61:0]        p_ff;
   logic [BIG_W-1:0]   big_ff, big_in;
   logic [31:0]        im_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [31:0]        rx_ff, ry_ff;
   logic               axis_y_ff;
   logic               dneg_ff;
   logic signed [33:0] rel_ff;
   logic [16:0]        e_ff;
   logic [32:0]        den_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [DLT_W-1:0]   da_ff, db_ff;
   logic [1:0]         stat_ff;
   logic [135:0]       data_ff;

   // shared multiplier
   logic signed [OPR_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [PROD_W-1:0] prod_sh;

   // pair geometry
   logic [32:0]        adx, ady;
   logic               pick_y;
   logic [32:0]        push;
   logic               d_neg;
   logic signed [32:0] vdiff;
   logic signed [63:0] push64;
   logic signed [63:0] da64, db64;
   logic [BIG_W-1:0]   cap_src;
   logic [DLT_W-1:0]   cap_val;
   logic [17:0]        e_plus;

   // divider
   logic               div_start;
   logic [BIG_W-1:0]   div_rem_init;
   logic [MAG_W-1:0]   div_dividend;
   logic [BIG_W-1:0]   div_divisor;
   logic [STEP_W-1:0]  div_steps;
   logic               div_busy;
   logic [MAG_W-1:0]   div_quo;

   logic [CNT_W+4:0]   count_ext;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cx_ff   <= req_data[35:4];
         cy_ff   <= req_data[67:36];
         hw_ff   <= req_data[98:68];
         hh_ff   <= req_data[129:99];
         dens_ff <= req_data[160:130];
         rest_ff <= req_data[177:161];
         dt_ff   <= req_data[194:178];
      end
   end

   // memory write data
   always_comb begin
      mem_wr    = 1'b0;
      mem_wdata = a_ff;
      case (cmd.op)
         OP_WRITE_A: begin
            mem_wr = 1'b1;
         end
         OP_WRITE_B: begin
            mem_wr    = 1'b1;
            mem_wdata = b_ff;
         end
         OP_WRITE_NEW: begin
            mem_wr             = 1'b1;
            mem_wdata.pos_x    = cx_ff;
            mem_wdata.pos_y    = cy_ff;
            mem_wdata.vel_x    = '0;
            mem_wdata.vel_y    = '0;
            mem_wdata.ext_x    = hw_ff;
            mem_wdata.ext_y    = hh_ff;
            mem_wdata.inv_mass = im_ff;
            mem_wdata.bounce   = (rest_ff > ONE_Q16) ? ONE_Q16 : rest_ff;
         end
         default: begin
            mem_wr = 1'b0;
         end
      endcase
   end

   // table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         box_mem_ff[addr] <= mem_wdata;
      end
      rd_q_ff <= box_mem_ff[addr];
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_HWHH: begin
            mul_a = {3'b0, hw_ff};
            mul_b = {3'b0, hh_ff};
         end
         MUL_PLO: begin
            mul_a = {3'b0, p_ff[30:0]};
            mul_b = {3'b0, dens_ff};
         end
         MUL_PHI: begin
            mul_a = {3'b0, p_ff[61:31]};
            mul_b = {3'b0, dens_ff};
         end
         MUL_VX: begin
            mul_a = {{2{a_ff.vel_x[31]}}, a_ff.vel_x};
            mul_b = {17'b0, dt_ff};
         end
         MUL_VY: begin
            mul_a = {{2{a_ff.vel_y[31]}}, a_ff.vel_y};
            mul_b = {17'b0, dt_ff};
         end
         MUL_NUM: begin
            mul_a = {16'b0, e_plus};
            mul_b = rel_ff;
         end
         MUL_MLO_A: begin
            mul_a = {9'b0, mag_ff[24:0]};
            mul_b = {2'b0, a_ff.inv_mass};
         end
         MUL_MHI_A: begin
            mul_a = {10'b0, mag_ff[MAG_W-1:25]};
            mul_b = {2'b0, a_ff.inv_mass};
         end
         MUL_MLO_B: begin
            mul_a = {9'b0, mag_ff[24:0]};
            mul_b = {2'b0, b_ff.inv_mass};
         end
         MUL_MHI_B: begin
            mul_a = {10'b0, mag_ff[MAG_W-1:25]};
            mul_b = {2'b0, b_ff.inv_mass};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign e_plus  = {1'b0, ONE_Q16} + {1'b0, e_ff};
   assign product = mul_a * mul_b;
   assign prod_sh = prod_ff >>> 16;

   // product register
   always_ff @(posedge clock) begin
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= product;
      end
   end

   // accumulator for split products
   always_comb begin
      big_in = big_ff;
      case (cmd.acc_op)
         ACC_SET:   big_in = {25'b0, prod_ff};
         ACC_ADD31: big_in = big_ff + ({25'b0, prod_ff} << 31);
         ACC_ADD25: big_in = big_ff + ({25'b0, prod_ff} << 25);
         default:   big_in = big_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      big_ff <= big_in;
   end

   // pair geometry from registered distances
   always_comb begin
      adx    = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      ady    = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      pick_y = !(adx >= ady);
      d_neg  = pick_y ? dy_ff[32] : dx_ff[32];
      push   = pick_y ? ({1'b0, ry_ff} - ady) : ({1'b0, rx_ff} - adx);
      push64 = d_neg ? -$signed({31'b0, push}) : $signed({31'b0, push});
      vdiff  = pick_y ? ($signed({b_ff.vel_y[31], b_ff.vel_y})
                         - $signed({a_ff.vel_y[31], a_ff.vel_y}))
                      : ($signed({b_ff.vel_x[31], b_ff.vel_x})
                         - $signed({a_ff.vel_x[31], a_ff.vel_x}));
      cap_src = big_ff >> 16;
      cap_val = (cap_src > (BIG_W'(1) << 40)) ? (DLT_W'(1) << 40) : cap_src[DLT_W-1:0];
      da64    = $signed({23'b0, da_ff});
      db64    = $signed({23'b0, db_ff});
   end

   // working box updates
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      case (cmd.op)
         OP_LOAD_A: a_in = rd_q_ff;
         OP_LOAD_B: b_in = rd_q_ff;
         OP_MOVE_X: a_in.pos_x = sat32({{32{a_ff.pos_x[31]}}, a_ff.pos_x}
                                       + prod_sh[63:0]);
         OP_MOVE_Y: a_in.pos_y = sat32({{32{a_ff.pos_y[31]}}, a_ff.pos_y}
                                       + prod_sh[63:0]);
         OP_SEP: begin
            if (pick_y) begin
               b_in.pos_y = sat32({{32{b_ff.pos_y[31]}}, b_ff.pos_y} + push64);
            end else begin
               b_in.pos_x = sat32({{32{b_ff.pos_x[31]}}, b_ff.pos_x} + push64);
            end
         end
         OP_APPLY: begin
            if (axis_y_ff) begin
               a_in.vel_y = sat32({{32{a_ff.vel_y[31]}}, a_ff.vel_y}
                                  + (dneg_ff ? da64 : -da64));
               b_in.vel_y = sat32({{32{b_ff.vel_y[31]}}, b_ff.vel_y}
                                  + (dneg_ff ? -db64 : db64));
            end else begin
               a_in.vel_x = sat32({{32{a_ff.vel_x[31]}}, a_ff.vel_x}
                                  + (dneg_ff ? da64 : -da64));
               b_in.vel_x = sat32({{32{b_ff.vel_x[31]}}, b_ff.vel_x}
                                  + (dneg_ff ? -db64 : db64));
            end
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      if (cmd.op == OP_SAVE_P) begin
         p_ff <= prod_ff[61:0];
      end
      if (cmd.op == OP_IM_SAT) begin
         im_ff <= '1;
      end else if (cmd.op == OP_TAKE_IM) begin
         im_ff <= div_quo[31:0];
      end
      if (cmd.op == OP_DIFF) begin
         dx_ff <= $signed({b_ff.pos_x[31], b_ff.pos_x}) - $signed({a_ff.pos_x[31], a_ff.pos_x});
         dy_ff <= $signed({b_ff.pos_y[31], b_ff.pos_y}) - $signed({a_ff.pos_y[31], a_ff.pos_y});
         rx_ff <= {1'b0, a_ff.ext_x} + {1'b0, b_ff.ext_x};
         ry_ff <= {1'b0, a_ff.ext_y} + {1'b0, b_ff.ext_y};
      end
      if (cmd.op == OP_SEP) begin
         axis_y_ff <= pick_y;
         dneg_ff   <= d_neg;
         rel_ff    <= d_neg ? $signed({vdiff[32], vdiff}) : -$signed({vdiff[32], vdiff});
         e_ff      <= (a_ff.bounce < b_ff.bounce) ? a_ff.bounce : b_ff.bounce;
         den_ff    <= {1'b0, a_ff.inv_mass} + {1'b0, b_ff.inv_mass};
      end
      if (cmd.op == OP_TAKE_MAG) begin
         mag_ff <= div_quo;
      end
      if (cmd.op == OP_CAP_A) begin
         da_ff <= cap_val;
      end
      if (cmd.op == OP_CAP_B) begin
         db_ff <= cap_val;
      end
   end

   // divider start for inverse mass or impulse magnitude
   always_comb begin
      div_start    = 1'b0;
      div_rem_init = '0;
      div_dividend = prod_ff[MAG_W-1:0];
      div_divisor  = {60'b0, den_ff};
      div_steps    = STEP_W'(MAG_W);
      case (cmd.op)
         OP_DIV_IM: begin
            div_start    = 1'b1;
            div_rem_init = BIG_W'(1) << 32;
            div_dividend = '0;
            div_divisor  = big_ff;
            div_steps    = STEP_W'(32);
         end
         OP_DIV_MAG: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   aics_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // result register
   assign count_ext = {5'b0, count};

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         data_ff[135:128] <= {3'b0, count_ext[4:0]};
         case (cmd.res_sel)
            RES_READ: begin
               stat_ff         <= STAT_OK;
               data_ff[127:0]  <= {a_ff.vel_y, a_ff.vel_x, a_ff.pos_y, a_ff.pos_x};
            end
            RES_FULL: begin
               stat_ff        <= STAT_FULL;
               data_ff[127:0] <= '0;
            end
            RES_RANGE: begin
               stat_ff        <= STAT_RANGE;
               data_ff[127:0] <= '0;
            end
            default: begin
               stat_ff        <= STAT_OK;
               data_ff[127:0] <= '0;
            end
         endcase
      end
   end

   // status to controller
   assign stat.overlap    = (adx <= {1'b0, rx_ff}) && (ady <= {1'b0, ry_ff});
   assign stat.approach   = (rel_ff > 34'sd0) && (den_ff != 33'd0);
   assign stat.small_mass = (big_ff <= (BIG_W'(1) << 32));
   assign stat.div_busy   = div_busy;

   assign res_status = stat_ff;
   assign res_data   = data_ff;

endmodule
`default_nettype wire

@@ hdl/aics_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aics_controller
// Command sequencer: table count, box loop counters and handshakes.
// ----------------------------------------------------------------------------
module aics_controller import aics_pkg::*; #(
   parameter int MAX_BOXES = DEF_MAX_BOXES,
   parameter int ADDR_W    = $clog2(MAX_BOXES),
   parameter int CNT_W     = $clog2(MAX_BOXES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [3:0]         req_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dp_cmd_type              cmd,
   input  wire dp_stat_type        stat,
   output logic [ADDR_W-1:0]       addr,
   output logic [CNT_W-1:0]        count
);

   ctl_state_type       state_ff, state_in;
   cmd_type             op_ff;
   logic [3:0]          idx_ff;
   res_sel_type         res_ff, res_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                slot_free;
   logic [CNT_W+3:0]    idx_ext;
   logic [CNT_W+3:0]    cnt_ext;
   logic                i_last;
   logic                j_last;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign idx_ext   = {{CNT_W{1'b0}}, idx_ff};
   assign cnt_ext   = {4'b0, count_ff};
   assign i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;
   assign j_last    = (j_ff + ADDR_W'(1)) == i_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (accept) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (op_ff)
               CMD_ADD:  state_in = (count_ff == CNT_W'(MAX_BOXES)) ? S_RESULT : S_ADD_M1;
               CMD_STEP: state_in = (count_ff == '0) ? S_RESULT : S_MV_RA;
               CMD_READ: state_in = (idx_ext >= cnt_ext) ? S_RESULT : S_RD_ADDR;
               default:  state_in = S_RESULT;
            endcase
         end
         S_ADD_M1:    state_in = S_ADD_M2;
         S_ADD_M2:    state_in = S_ADD_M3;
         S_ADD_M3:    state_in = S_ADD_M4;
         S_ADD_M4:    state_in = S_ADD_M5;
         S_ADD_M5:    state_in = S_ADD_CHK;
         S_ADD_CHK:   state_in = stat.small_mass ? S_ADD_WR : S_ADD_DIV0;
         S_ADD_DIV0:  state_in = S_ADD_DIV;
         S_ADD_DIV:   if (!stat.div_busy) state_in = S_ADD_TAKE;
         S_ADD_TAKE:  state_in = S_ADD_WR;
         S_ADD_WR:    state_in = S_RESULT;
         S_RD_ADDR:   state_in = S_RD_LOAD;
         S_RD_LOAD:   state_in = S_RESULT;
         S_MV_RA:     state_in = S_MV_LA;
         S_MV_LA:     state_in = S_MV_MX;
         S_MV_MX:     state_in = S_MV_AX;
         S_MV_AX:     state_in = S_MV_AY;
         S_MV_AY:     state_in = (i_ff == '0) ? S_MV_WA : S_PR_RB;
         S_PR_RB:     state_in = S_PR_LB;
         S_PR_LB:     state_in = S_PR_DIFF;
         S_PR_DIFF:   state_in = S_PR_TEST;
         S_PR_TEST:   state_in = stat.overlap ? S_PR_APPR : S_PR_NEXT;
         S_PR_APPR:   state_in = stat.approach ? S_PR_DIV0 : S_PR_WB;
         S_PR_DIV0:   state_in = S_PR_DIV;
         S_PR_DIV:    if (!stat.div_busy) state_in = S_PR_TAKE;
         S_PR_TAKE:   state_in = S_SC1;
         S_SC1:       state_in = S_SC2;
         S_SC2:       state_in = S_SC3;
         S_SC3:       state_in = S_SC4;
         S_SC4:       state_in = S_SC5;
         S_SC5:       state_in = S_SC6;
         S_SC6:       state_in = S_PR_UPD;
         S_PR_UPD:    state_in = S_PR_WB;
         S_PR_WB:     state_in = S_PR_NEXT;
         S_PR_NEXT:   state_in = j_last ? S_MV_WA : S_PR_RB;
         S_MV_WA:     state_in = i_last ? S_RESULT : S_MV_RA;
         S_RESULT:    if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath commands and addresses
   always_comb begin
      cmd          = '0;
      cmd.op       = OP_NONE;
      cmd.mul_sel  = MUL_NONE;
      cmd.acc_op   = ACC_NONE;
      cmd.res_sel  = res_ff;
      cmd.capture  = accept;
      addr         = i_ff;
      req_ready    = (state_ff == S_IDLE);
      case (state_ff)
         S_ADD_M1:   cmd.mul_sel = MUL_HWHH;
         S_ADD_M2:   cmd.op = OP_SAVE_P;
         S_ADD_M3:   cmd.mul_sel = MUL_PLO;
         S_ADD_M4: begin
            cmd.mul_sel = MUL_PHI;
            cmd.acc_op  = ACC_SET;
         end
         S_ADD_M5:   cmd.acc_op = ACC_ADD31;
         S_ADD_CHK:  if (stat.small_mass) cmd.op = OP_IM_SAT;
         S_ADD_DIV0: cmd.op = OP_DIV_IM;
         S_ADD_TAKE: cmd.op = OP_TAKE_IM;
         S_ADD_WR: begin
            cmd.op = OP_WRITE_NEW;
            addr   = count_ff[ADDR_W-1:0];
         end
         S_RD_ADDR:  addr = idx_ext[ADDR_W-1:0];
         S_RD_LOAD:  cmd.op = OP_LOAD_A;
         S_MV_LA:    cmd.op = OP_LOAD_A;
         S_MV_MX:    cmd.mul_sel = MUL_VX;
         S_MV_AX: begin
            cmd.op      = OP_MOVE_X;
            cmd.mul_sel = MUL_VY;
         end
         S_MV_AY:    cmd.op = OP_MOVE_Y;
         S_PR_RB:    addr = j_ff;
         S_PR_LB:    cmd.op = OP_LOAD_B;
         S_PR_DIFF:  cmd.op = OP_DIFF;
         S_PR_TEST:  if (stat.overlap) cmd.op = OP_SEP;
         S_PR_APPR:  if (stat.approach) cmd.mul_sel = MUL_NUM;
         S_PR_DIV0:  cmd.op = OP_DIV_MAG;
         S_PR_TAKE:  cmd.op = OP_TAKE_MAG;
         S_SC1:      cmd.mul_sel = MUL_MLO_A;
         S_SC2: begin
            cmd.mul_sel = MUL_MHI_A;
            cmd.acc_op  = ACC_SET;
         end
         S_SC3: begin
            cmd.mul_sel = MUL_MLO_B;
            cmd.acc_op  = ACC_ADD25;
         end
         S_SC4: begin
            cmd.op      = OP_CAP_A;
            cmd.mul_sel = MUL_MHI_B;
            cmd.acc_op  = ACC_SET;
         end
         S_SC5:      cmd.acc_op = ACC_ADD25;
         S_SC6:      cmd.op = OP_CAP_B;
         S_PR_UPD:   cmd.op = OP_APPLY;
         S_PR_WB: begin
            cmd.op = OP_WRITE_B;
            addr   = j_ff;
         end
         S_MV_WA:    cmd.op = OP_WRITE_A;
         S_RESULT:   cmd.res_load = slot_free;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // counters, result kind and output valid
   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      res_in   = res_ff;
      case (state_ff)
         S_DISPATCH: begin
            i_in   = '0;
            res_in = RES_OK;
            if (op_ff == CMD_ADD && count_ff == CNT_W'(MAX_BOXES)) begin
               res_in = RES_FULL;
            end else if (op_ff == CMD_READ) begin
               res_in = (idx_ext >= cnt_ext) ? RES_RANGE : RES_READ;
            end
         end
         S_ADD_WR:  count_in = count_ff + CNT_W'(1);
         S_MV_AY:   j_in = '0;
         S_PR_NEXT: j_in = j_ff + ADDR_W'(1);
         S_MV_WA:   i_in = i_ff + ADDR_W'(1);
         default:   count_in = count_ff;
      endcase
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request decode and loop registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= cmd_type'(req_cmd);
         idx_ff <= req_index;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      res_ff <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign count     = count_ff;

endmodule
`default_nettype wire

@@ hdl/aabb_impulse_collision_step_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_impulse_collision_step_unit
// Table of 2D axis-aligned boxes with motion and impulse collision response.
//
//  channel | direction | contents
//  req     | in        | tuser: cmd; tdata: box and step fields
//  rsp     | out       | tuser: status; tdata: read box and count
//
// Add runs the 32-step inverse mass division only when the mass is not small,
// and saturates the inverse mass otherwise. A step moves each box and tests it
// against every earlier box; an overlapping pair is pushed apart, and one that
// also approaches gets an impulse from the divider and the shared multiplier.
// Reset clears the box count and response valid and returns to idle. A result
// left waiting holds the next one in its final state until the slot frees.
// ----------------------------------------------------------------------------
module aabb_impulse_collision_step_unit import aics_pkg::*; #(
   parameter int MAX_BOXES = DEF_MAX_BOXES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [3:0] box_index, [35:4] center_x, [67:36] center_y, [98:68] half_w,
   // [129:99] half_h, [160:130] density, [177:161] restitution, [194:178] dt
   input  wire logic [199:0]  req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [31:0] out_center_x, [63:32] out_center_y, [95:64] out_vel_x,
   // [127:96] out_vel_y, [132:128] count_now
   output logic [135:0]       rsp_tdata,
   // [1:0] status
   output logic [1:0]         rsp_tuser
);

   localparam int ADDR_W = $clog2(MAX_BOXES);
   localparam int CNT_W  = $clog2(MAX_BOXES + 1);

   dp_cmd_type          dp_cmd;
   dp_stat_type         dp_stat;
   logic [ADDR_W-1:0]   dp_addr;
   logic [CNT_W-1:0]    dp_count;

   // sequencer
   aics_controller #(
      .MAX_BOXES (MAX_BOXES),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_index (req_tdata[3:0]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .addr      (dp_addr),
      .count     (dp_count)
   );

   // arithmetic and table
   aics_datapath #(
      .MAX_BOXES (MAX_BOXES),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .addr       (dp_addr),
      .count      (dp_count),
      .req_data   (req_tdata),
      .res_status (rsp_tuser),
      .res_data   (rsp_tdata)
   );

endmodule
`default_nettype wire
